FILE: src/mpso_pkg.sv
package mpso_pkg;

  // Default number of metered ports (two per metering chip).
  localparam int NumPortsDef = 12;

  // Field widths.
  localparam int ChipW   = 3;
  localparam int RawW    = 24;
  localparam int ScaledW = 31;
  localparam int VoltW   = 28;
  localparam int CurrW   = 31;
  localparam int PowW    = 30;
  localparam int GainW   = 16;
  localparam int LimW    = 31;
  localparam int RunW    = 8;
  localparam int IdxOutW = 4;
  localparam int DivisorW = 20;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgVoltGain  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCurrAGain = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCurrBGain = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPowAGain  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPowBGain  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgVoltLimit = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgCurrLimit = 3'd6;

  // Configuration reset values.
  localparam logic [GainW-1:0] VoltGainRst  = 16'd17127;
  localparam logic [GainW-1:0] CurrAGainRst = 16'd27486;
  localparam logic [GainW-1:0] CurrBGainRst = 16'd27490;
  localparam logic [GainW-1:0] PowAGainRst  = 16'd8276;
  localparam logic [GainW-1:0] PowBGainRst  = 16'd8276;
  localparam logic [LimW-1:0]  VoltLimitRst = 31'd2500;
  localparam logic [LimW-1:0]  CurrLimitRst = 31'd1000;

  typedef struct packed {
    logic              frame_ok;
    logic [ChipW-1:0]  chip;
    logic [RawW-1:0]   ia_raw;
    logic [RawW-1:0]   ib_raw;
    logic [RawW-1:0]   v_raw;
    logic [RawW-1:0]   pa_raw;
    logic [RawW-1:0]   pb_raw;
  } in_t;

  typedef struct packed {
    logic [IdxOutW-1:0] port_index;
    logic [VoltW-1:0]   port_voltage;
    logic [CurrW-1:0]   port_current;
    logic [PowW-1:0]    port_power;
    logic               over_voltage;
    logic               over_current;
    logic               last_port;
  } out_t;

  typedef struct packed {
    logic [GainW-1:0] volt_gain;
    logic [GainW-1:0] curr_a_gain;
    logic [GainW-1:0] curr_b_gain;
    logic [GainW-1:0] pow_a_gain;
    logic [GainW-1:0] pow_b_gain;
    logic [LimW-1:0]  volt_limit;
    logic [LimW-1:0]  curr_limit;
  } cfg_t;

  // Classified reading passed from the front to the back.
  typedef struct packed {
    logic               chip_ok;
    logic [ChipW-1:0]   chip;
    logic [ScaledW-1:0] v_sc;
    logic [ScaledW-1:0] ia_sc;
    logic [ScaledW-1:0] ib_sc;
    logic [ScaledW-1:0] pa_sc;
    logic [ScaledW-1:0] pb_sc;
  } cmd_t;

endpackage

FILE: src/meter_port_scaling_overlimit_unit.sv
// Port scaling and over-limit monitor for a bank of metering chips.
// Input channel: an item is one chip reading, taken when push is high and full
// is low. A reading with frame_ok low is taken and dropped and yields nothing.
// A valid reading is scaled (value times 100 over its gain register, voltage
// over ten times its gain) and stored for the chip's ports 2k and 2k+1; a chip
// index whose ports lie outside the bank stores nothing. Then every port is
// walked in ascending order and one status item per port is produced.
// Result channel: the oldest status item is on result_o while empty is low and
// is taken when pop is high. The last port's item carries last_port.
// The five divisions share one bit-serial divider and run one after another.
// For a valid reading the back end takes it from the queue, runs the five
// divisions, makes two store writes and then walks the ports, with a read
// and an emit state per port; its first status item follows the store writes.
// A chip outside the bank skips the divisions and the store writes and goes
// straight to the walk. A two-entry queue in front lets up to two readings
// wait meanwhile, and a two-entry result queue decouples the walk from the
// receiver. When the receiver stalls, the walk pauses on a full result queue
// and nothing is lost. Configuration writes are always ready and take effect
// at once; write them only while the block is idle. Reset restores the register
// defaults and makes all stored values, run counters and flags read as zero.
module meter_port_scaling_overlimit_unit #(
  parameter int NumPorts = mpso_pkg::NumPortsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  mpso_pkg::in_t                 item_i,
  output logic                          empty,
  input  logic                          pop,
  output mpso_pkg::out_t                result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mpso_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mpso_pkg::LimW-1:0]     cfg_data_i
);

  mpso_pkg::cfg_t cfg_q;
  mpso_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_pop;

  // Configuration registers; writes to unknown indexes are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volt_gain   <= mpso_pkg::VoltGainRst;
      cfg_q.curr_a_gain <= mpso_pkg::CurrAGainRst;
      cfg_q.curr_b_gain <= mpso_pkg::CurrBGainRst;
      cfg_q.pow_a_gain  <= mpso_pkg::PowAGainRst;
      cfg_q.pow_b_gain  <= mpso_pkg::PowBGainRst;
      cfg_q.volt_limit  <= mpso_pkg::VoltLimitRst;
      cfg_q.curr_limit  <= mpso_pkg::CurrLimitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mpso_pkg::CfgVoltGain:  cfg_q.volt_gain   <= cfg_data_i[mpso_pkg::GainW-1:0];
        mpso_pkg::CfgCurrAGain: cfg_q.curr_a_gain <= cfg_data_i[mpso_pkg::GainW-1:0];
        mpso_pkg::CfgCurrBGain: cfg_q.curr_b_gain <= cfg_data_i[mpso_pkg::GainW-1:0];
        mpso_pkg::CfgPowAGain:  cfg_q.pow_a_gain  <= cfg_data_i[mpso_pkg::GainW-1:0];
        mpso_pkg::CfgPowBGain:  cfg_q.pow_b_gain  <= cfg_data_i[mpso_pkg::GainW-1:0];
        mpso_pkg::CfgVoltLimit: cfg_q.volt_limit  <= cfg_data_i;
        mpso_pkg::CfgCurrLimit: cfg_q.curr_limit  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front end: classifies and pre-scales readings into the command queue.
  mpso_front #(
    .NumPorts(NumPorts)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item_i),
    .full_o     (full),
    .cmd_pop_i  (cmd_pop),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd)
  );

  // Back end: divisions, port stores and the status walk.
  mpso_back #(
    .NumPorts(NumPorts)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .result_o   (result_o)
  );

endmodule

FILE: src/mpso_ram.sv
module mpso_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/mpso_fifo.sv
module mpso_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  // Two-entry queue.
  logic [Width-1:0] mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: src/mpso_div.sv
module mpso_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mpso_pkg::ScaledW-1:0]  dividend_i,
  input  logic [mpso_pkg::DivisorW-1:0] divisor_i,
  output logic                          done_o,
  output logic [mpso_pkg::ScaledW-1:0]  quotient_o
);

  localparam int QW = mpso_pkg::ScaledW;
  localparam int DW = mpso_pkg::DivisorW;
  localparam int CntW = $clog2(QW);
  localparam logic [CntW-1:0] LastStep = CntW'(QW - 1);

  // Restoring division, one quotient bit per cycle.
  logic [DW:0]     rem_q, rem_d, rem_sh;
  logic [QW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   div_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic            fits;

  always_comb begin
    rem_sh = {rem_q[DW-1:0], quo_q[QW-1]};
    fits   = (rem_sh >= {1'b0, div_q});
    rem_d  = fits ? (rem_sh - {1'b0, div_q}) : rem_sh;
    quo_d  = {quo_q[QW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: src/mpso_front.sv
module mpso_front #(
  parameter int NumPorts = mpso_pkg::NumPortsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mpso_pkg::in_t        item_i,
  output logic                 full_o,
  input  logic                 cmd_pop_i,
  output logic                 cmd_valid_o,
  output mpso_pkg::cmd_t       cmd_o
);

  localparam int SW = mpso_pkg::ScaledW;
  localparam int RW = mpso_pkg::RawW;
  localparam logic [SW-1:0] ScaleMul = SW'(100);
  localparam logic [RW-1:0] PosMax   = 24'h7fffff;
  localparam logic [RW:0]   Modulus  = 25'h1000000;
  localparam logic [6:0]    PortsLim = 7'(NumPorts);

  mpso_pkg::cmd_t cmd_d;
  logic           cmd_full, cmd_empty;
  logic [RW-1:0]  pa_mag, pb_mag;

  // Power words are two's complement; keep the magnitude only.
  assign pa_mag = (item_i.pa_raw > PosMax) ? RW'(Modulus - {1'b0, item_i.pa_raw})
                                           : item_i.pa_raw;
  assign pb_mag = (item_i.pb_raw > PosMax) ? RW'(Modulus - {1'b0, item_i.pb_raw})
                                           : item_i.pb_raw;

  always_comb begin
    cmd_d.chip    = item_i.chip;
    cmd_d.chip_ok = ({3'b000, item_i.chip, 1'b1} < PortsLim);
    cmd_d.v_sc    = SW'(item_i.v_raw) * ScaleMul;
    cmd_d.ia_sc   = SW'(item_i.ia_raw) * ScaleMul;
    cmd_d.ib_sc   = SW'(item_i.ib_raw) * ScaleMul;
    cmd_d.pa_sc   = SW'(pa_mag) * ScaleMul;
    cmd_d.pb_sc   = SW'(pb_mag) * ScaleMul;
  end

  // Invalid readings are taken and dropped here.
  mpso_fifo #(
    .Width($bits(mpso_pkg::cmd_t))
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i & item_i.frame_ok),
    .data_i (cmd_d),
    .full_o (cmd_full),
    .pop_i  (cmd_pop_i),
    .empty_o(cmd_empty),
    .data_o (cmd_o)
  );

  assign full_o      = cmd_full;
  assign cmd_valid_o = ~cmd_empty;

endmodule

FILE: src/mpso_back.sv
module mpso_back #(
  parameter int NumPorts = mpso_pkg::NumPortsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mpso_pkg::cfg_t       cfg_i,
  input  logic                 cmd_valid_i,
  input  mpso_pkg::cmd_t       cmd_i,
  output logic                 cmd_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output mpso_pkg::out_t       result_o
);

  localparam int PortW = $clog2(NumPorts);
  localparam int SW    = mpso_pkg::ScaledW;
  localparam int DW    = mpso_pkg::DivisorW;
  localparam int RunW  = mpso_pkg::RunW;
  localparam logic [PortW-1:0] LastPort = PortW'(NumPorts - 1);
  localparam logic [RunW-1:0]  RunThr   = RunW'(10);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_WR_A  = 3'd3;
  localparam logic [2:0] S_WR_B  = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam logic [2:0] OpVolt = 3'd0;
  localparam logic [2:0] OpCurA = 3'd1;
  localparam logic [2:0] OpCurB = 3'd2;
  localparam logic [2:0] OpPowA = 3'd3;
  localparam logic [2:0] OpPowB = 3'd4;

  typedef struct packed {
    logic [mpso_pkg::VoltW-1:0] volt;
    logic [mpso_pkg::CurrW-1:0] curr;
    logic [mpso_pkg::PowW-1:0]  power;
  } meas_t;

  typedef struct packed {
    logic [RunW-1:0] vrun;
    logic [RunW-1:0] crun;
    logic            ov;
    logic            oc;
  } trk_t;

  logic [2:0]           state_q, state_d;
  logic [2:0]           op_q;
  mpso_pkg::cmd_t       cmd_q;
  logic [mpso_pkg::VoltW-1:0] volt_q;
  logic [mpso_pkg::CurrW-1:0] cura_q, curb_q;
  logic [mpso_pkg::PowW-1:0]  powa_q, powb_q;
  logic [PortW-1:0]     idx_q;
  logic [NumPorts-1:0]  meas_vld_q, trk_vld_q;
  logic                 rd_mv_q, rd_tv_q;

  logic [SW-1:0]        dividend, quotient;
  logic [mpso_pkg::GainW-1:0] gain, gain_nz;
  logic [DW-1:0]        divisor;
  logic                 div_start, div_done;

  logic [PortW-1:0]     base_addr, wr_addr;
  logic                 meas_we, trk_we;
  meas_t                meas_wr, meas_rd, meas_cur;
  trk_t                 trk_rd, trk_cur, trk_new;
  logic [RunW-1:0]      vrun_inc, crun_inc;
  logic                 v_over, c_over;
  mpso_pkg::out_t       res_d;
  logic                 res_push, res_full;

  // Divider operand selection.
  always_comb begin
    dividend = cmd_q.v_sc;
    gain     = cfg_i.volt_gain;
    case (op_q)
      OpVolt: begin
        dividend = cmd_q.v_sc;
        gain     = cfg_i.volt_gain;
      end
      OpCurA: begin
        dividend = cmd_q.ia_sc;
        gain     = cfg_i.curr_a_gain;
      end
      OpCurB: begin
        dividend = cmd_q.ib_sc;
        gain     = cfg_i.curr_b_gain;
      end
      OpPowA: begin
        dividend = cmd_q.pa_sc;
        gain     = cfg_i.pow_a_gain;
      end
      OpPowB: begin
        dividend = cmd_q.pb_sc;
        gain     = cfg_i.pow_b_gain;
      end
      default: begin
        dividend = cmd_q.v_sc;
        gain     = cfg_i.volt_gain;
      end
    endcase
    gain_nz = (gain == '0) ? mpso_pkg::GainW'(1) : gain;
    // The extra divide by ten of the voltage folds into the divisor.
    if (op_q == OpVolt) begin
      divisor = (DW'(gain_nz) << 3) + (DW'(gain_nz) << 1);
    end else begin
      divisor = DW'(gain_nz);
    end
  end

  assign div_start = (state_q == S_START);

  mpso_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(dividend),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  // Measurement store: chip k owns ports 2k and 2k+1.
  assign base_addr = PortW'({cmd_q.chip, 1'b0});
  assign wr_addr   = (state_q == S_WR_B) ? (base_addr + PortW'(1)) : base_addr;
  assign meas_we   = (state_q == S_WR_A) || (state_q == S_WR_B);

  always_comb begin
    meas_wr.volt  = volt_q;
    meas_wr.curr  = (state_q == S_WR_B) ? curb_q : cura_q;
    meas_wr.power = (state_q == S_WR_B) ? powb_q : powa_q;
  end

  mpso_ram #(
    .Width($bits(meas_t)),
    .Depth(NumPorts)
  ) u_meas_ram (
    .clk_i  (clk_i),
    .we_i   (meas_we),
    .waddr_i(wr_addr),
    .wdata_i(meas_wr),
    .raddr_i(idx_q),
    .rdata_o(meas_rd)
  );

  mpso_ram #(
    .Width($bits(trk_t)),
    .Depth(NumPorts)
  ) u_trk_ram (
    .clk_i  (clk_i),
    .we_i   (trk_we),
    .waddr_i(idx_q),
    .wdata_i(trk_new),
    .raddr_i(idx_q),
    .rdata_o(trk_rd)
  );

  // Over-limit tracking of the port being walked.
  always_comb begin
    meas_cur = rd_mv_q ? meas_rd : '0;
    trk_cur  = rd_tv_q ? trk_rd : '0;
    v_over   = ({3'b000, meas_cur.volt} > cfg_i.volt_limit);
    c_over   = (meas_cur.curr > cfg_i.curr_limit);
    vrun_inc = trk_cur.vrun + RunW'(1);
    crun_inc = trk_cur.crun + RunW'(1);
    trk_new.vrun = v_over ? vrun_inc : '0;
    trk_new.ov   = v_over & ((vrun_inc > RunThr) | trk_cur.ov);
    trk_new.crun = c_over ? crun_inc : '0;
    trk_new.oc   = c_over & ((crun_inc > RunThr) | trk_cur.oc);
  end

  assign trk_we   = (state_q == S_EMIT);
  assign res_push = (state_q == S_EMIT);

  always_comb begin
    res_d.port_index   = mpso_pkg::IdxOutW'({4'b0000, idx_q});
    res_d.port_voltage = meas_cur.volt;
    res_d.port_current = meas_cur.curr;
    res_d.port_power   = meas_cur.power;
    res_d.over_voltage = trk_new.ov;
    res_d.over_current = trk_new.oc;
    res_d.last_port    = (idx_q == LastPort);
  end

  mpso_fifo #(
    .Width($bits(mpso_pkg::out_t))
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_d),
    .full_o (res_full),
    .pop_i  (pop_i),
    .empty_o(empty_o),
    .data_o (result_o)
  );

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          state_d   = cmd_i.chip_ok ? S_START : S_RD;
        end
      end
      S_START: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          state_d = (op_q == OpPowB) ? S_WR_A : S_START;
        end
      end
      S_WR_A: begin
        state_d = S_WR_B;
      end
      S_WR_B: begin
        state_d = S_RD;
      end
      S_RD: begin
        // Only the walk fills the result queue, so space seen here holds.
        if (!res_full) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        state_d = (idx_q == LastPort) ? S_IDLE : S_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= OpVolt;
      idx_q      <= '0;
      meas_vld_q <= '0;
      trk_vld_q  <= '0;
      rd_mv_q    <= 1'b0;
      rd_tv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_mv_q <= meas_vld_q[idx_q];
      rd_tv_q <= trk_vld_q[idx_q];
      if (state_q == S_IDLE) begin
        op_q  <= OpVolt;
        idx_q <= '0;
      end
      if ((state_q == S_WAIT) && div_done) begin
        op_q <= op_q + 3'd1;
      end
      if (meas_we) begin
        meas_vld_q[wr_addr] <= 1'b1;
      end
      if (state_q == S_EMIT) begin
        trk_vld_q[idx_q] <= 1'b1;
        idx_q            <= idx_q + PortW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if ((state_q == S_WAIT) && div_done) begin
      case (op_q)
        OpVolt:  volt_q <= mpso_pkg::VoltW'(quotient);
        OpCurA:  cura_q <= mpso_pkg::CurrW'(quotient);
        OpCurB:  curb_q <= mpso_pkg::CurrW'(quotient);
        OpPowA:  powa_q <= mpso_pkg::PowW'(quotient);
        OpPowB:  powb_q <= mpso_pkg::PowW'(quotient);
        default: volt_q <= volt_q;
      endcase
    end
  end

endmodule

FILE: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mpso_pkg::*;

  localparam int NumPorts = NumPortsDef;
  // The drain wait gives a dropped or slow reading time to finish in the back
  // end before the registers change.
  localparam int DrainCycles = 250;
  // Long receiver hold-off used once to fill the block and stall its input.
  localparam int HoldCycles = 600;
  // Cycles without any handshake before the run is declared hung.
  localparam int StallLimit = 4000;
  localparam int MaxReports = 10;

  // Clock, reset and block inputs. Every input starts at a known value.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  in_t item_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CfgVoltGain;
  logic [LimW-1:0] cfg_data_i = '0;
  logic full;
  logic empty;
  logic cfg_ready_o;
  out_t result_o;

  // Readings waiting to be offered, and status items still owed by the block.
  in_t reading_queue[$];
  out_t status_expected[$];

  int readings_offered = 0;
  int readings_taken = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  int tx_idle_pct = 17;
  int rx_idle_pct = 78;
  int rx_hold_left = 0;
  bit rx_hold_req = 1'b0;

  // Predictor copy of the configuration registers.
  logic [GainW-1:0] volt_gain;
  logic [GainW-1:0] curr_a_gain;
  logic [GainW-1:0] curr_b_gain;
  logic [GainW-1:0] pow_a_gain;
  logic [GainW-1:0] pow_b_gain;
  logic [LimW-1:0] volt_limit;
  logic [LimW-1:0] curr_limit;

  // Predictor copy of the per-port store, run counters and limit flags.
  logic [VoltW-1:0] volt_mem [NumPorts];
  logic [CurrW-1:0] curr_mem [NumPorts];
  logic [PowW-1:0] pow_mem [NumPorts];
  logic [RunW-1:0] volt_run [NumPorts];
  logic [RunW-1:0] curr_run [NumPorts];
  logic ov_flag [NumPorts];
  logic oc_flag [NumPorts];

  meter_port_scaling_overlimit_unit #(
    .NumPorts(NumPorts)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .item_i(item_i),
    .empty(empty),
    .pop(pop),
    .result_o(result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Raw word times 100 over its gain. A gain of zero divides by one.
  function automatic logic [31:0] scaled(logic [RawW-1:0] raw, logic [GainW-1:0] gain);
    logic [31:0] divisor;
    divisor = (gain == '0) ? 32'd1 : {16'd0, gain};
    return ({8'd0, raw} * 32'd100) / divisor;
  endfunction

  // Power words are two's complement; negative ones are folded to magnitude.
  function automatic logic [RawW-1:0] power_magnitude(logic [RawW-1:0] raw);
    return (raw > 24'h7fffff) ? RawW'(25'h1000000 - {1'b0, raw}) : raw;
  endfunction

  // Stores a valid reading for its two ports, then walks every port the way
  // the block does, updating the over-limit runs and queueing one status item
  // per port. An invalid reading leaves everything alone and owes nothing.
  function automatic void walk_ports(in_t rd);
    logic [31:0] volts;
    int base;
    out_t st;
    if (!rd.frame_ok) return;
    base = 2 * int'(rd.chip);
    // Chips 6 and 7 would own ports past the bank, so nothing is stored, but
    // the walk below still runs.
    if (base + 1 < NumPorts) begin
      volts = scaled(rd.v_raw, volt_gain) / 32'd10;
      volt_mem[base] = VoltW'(volts);
      volt_mem[base + 1] = VoltW'(volts);
      curr_mem[base] = CurrW'(scaled(rd.ia_raw, curr_a_gain));
      curr_mem[base + 1] = CurrW'(scaled(rd.ib_raw, curr_b_gain));
      pow_mem[base] = PowW'(scaled(power_magnitude(rd.pa_raw), pow_a_gain));
      pow_mem[base + 1] = PowW'(scaled(power_magnitude(rd.pb_raw), pow_b_gain));
    end
    for (int p = 0; p < NumPorts; p++) begin
      // The run counter wraps at 256; the flag then keeps its value while the
      // port stays over its limit, and drops at once when it falls back.
      if (volt_mem[p] > volt_limit) begin
        volt_run[p] = volt_run[p] + 8'd1;
        if (volt_run[p] > 8'd10) ov_flag[p] = 1'b1;
      end else begin
        volt_run[p] = '0;
        ov_flag[p] = 1'b0;
      end
      if (curr_mem[p] > curr_limit) begin
        curr_run[p] = curr_run[p] + 8'd1;
        if (curr_run[p] > 8'd10) oc_flag[p] = 1'b1;
      end else begin
        curr_run[p] = '0;
        oc_flag[p] = 1'b0;
      end
      st.port_index = IdxOutW'(p);
      st.port_voltage = volt_mem[p];
      st.port_current = curr_mem[p];
      st.port_power = pow_mem[p];
      st.over_voltage = ov_flag[p];
      st.over_current = oc_flag[p];
      st.last_port = (p == NumPorts - 1);
      status_expected.push_back(st);
    end
  endfunction

  // Only the first few mismatches are printed; the rest are just counted.
  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("mismatch: %s", msg);
  endfunction

  // Predictor side: follows every accepted register write and every accepted
  // reading at the rising edge at which the handshake completes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volt_gain = VoltGainRst;
      curr_a_gain = CurrAGainRst;
      curr_b_gain = CurrBGainRst;
      pow_a_gain = PowAGainRst;
      pow_b_gain = PowBGainRst;
      volt_limit = VoltLimitRst;
      curr_limit = CurrLimitRst;
      for (int p = 0; p < NumPorts; p++) begin
        volt_mem[p] = '0;
        curr_mem[p] = '0;
        pow_mem[p] = '0;
        volt_run[p] = '0;
        curr_run[p] = '0;
        ov_flag[p] = 1'b0;
        oc_flag[p] = 1'b0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgVoltGain:  volt_gain = cfg_data_i[GainW-1:0];
          CfgCurrAGain: curr_a_gain = cfg_data_i[GainW-1:0];
          CfgCurrBGain: curr_b_gain = cfg_data_i[GainW-1:0];
          CfgPowAGain:  pow_a_gain = cfg_data_i[GainW-1:0];
          CfgPowBGain:  pow_b_gain = cfg_data_i[GainW-1:0];
          CfgVoltLimit: volt_limit = cfg_data_i;
          CfgCurrLimit: curr_limit = cfg_data_i;
          default: ;
        endcase
      end
      if (push && !full) begin
        readings_taken++;
        walk_ports(item_i);
      end
    end
  end

  // Sender. A reading stays on the port until it is taken; only then, or
  // while push is low, does the sender pick the next one or idle.
  always @(negedge clk_i) begin
    if (rst_ni && (!push || readings_taken == readings_offered)) begin
      if (reading_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        item_i <= reading_queue.pop_front();
        push <= 1'b1;
        readings_offered++;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver. A requested hold-off keeps pop low for a long stretch so that
  // the result queue fills, the port walk stops and the input side backs up.
  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_left = HoldCycles;
      rx_hold_req = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Checker: every status item taken from the block is matched against the
  // oldest outstanding prediction, field by field.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && pop && !empty) begin
      if (status_expected.size() == 0) begin
        flag_error($sformatf("unexpected status item for port %0d", result_o.port_index));
      end else begin
        want = status_expected.pop_front();
        if (result_o.port_index !== want.port_index)
          flag_error($sformatf("port_index expected %0d got %0d",
                               want.port_index, result_o.port_index));
        if (result_o.port_voltage !== want.port_voltage)
          flag_error($sformatf("port %0d voltage expected %0d got %0d",
                               want.port_index, want.port_voltage, result_o.port_voltage));
        if (result_o.port_current !== want.port_current)
          flag_error($sformatf("port %0d current expected %0d got %0d",
                               want.port_index, want.port_current, result_o.port_current));
        if (result_o.port_power !== want.port_power)
          flag_error($sformatf("port %0d power expected %0d got %0d",
                               want.port_index, want.port_power, result_o.port_power));
        if (result_o.over_voltage !== want.over_voltage)
          flag_error($sformatf("port %0d over_voltage expected %0b got %0b",
                               want.port_index, want.over_voltage, result_o.over_voltage));
        if (result_o.over_current !== want.over_current)
          flag_error($sformatf("port %0d over_current expected %0b got %0b",
                               want.port_index, want.over_current, result_o.over_current));
        if (result_o.last_port !== want.last_port)
          flag_error($sformatf("port %0d last_port expected %0b got %0b",
                               want.port_index, want.last_port, result_o.last_port));
      end
    end
  end

  // Watchdog: the run is hung if no handshake of any kind completes for a
  // long time. The longest legal quiet stretch is the receiver hold-off plus
  // one reading's processing, well below the limit.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic in_t make_reading(bit ok, int chip, logic [RawW-1:0] ia,
                                       logic [RawW-1:0] ib, logic [RawW-1:0] v,
                                       logic [RawW-1:0] pa, logic [RawW-1:0] pb);
    in_t rd;
    rd.frame_ok = ok;
    rd.chip = ChipW'(chip);
    rd.ia_raw = ia;
    rd.ib_raw = ib;
    rd.v_raw = v;
    rd.pa_raw = pa;
    rd.pb_raw = pb;
    return rd;
  endfunction

  // Raw words lean on the interesting spots: zero, all ones, small values and
  // the sign boundary of the power words, besides fully random words.
  function automatic logic [RawW-1:0] random_raw(bit keep_nonzero);
    logic [RawW-1:0] raw;
    case ($urandom_range(9))
      0: raw = '0;
      1: raw = '1;
      2: raw = RawW'($urandom_range(1000));
      3: raw = RawW'(24'h7ffffe + $urandom_range(4));
      default: raw = RawW'($urandom);
    endcase
    if (keep_nonzero && raw == '0) raw = RawW'(1);
    return raw;
  endfunction

  // Queues random readings until the given number of valid ones is reached;
  // invalid readings and chips past the bank are mixed in as noise.
  task automatic queue_random(int count, bit keep_nonzero);
    in_t rd;
    int valid_left;
    valid_left = count;
    while (valid_left > 0) begin
      rd.frame_ok = ($urandom_range(99) < 90);
      rd.chip = ($urandom_range(99) < 88) ? ChipW'($urandom_range(5))
                                          : ChipW'($urandom_range(7, 6));
      rd.ia_raw = random_raw(keep_nonzero);
      rd.ib_raw = random_raw(keep_nonzero);
      rd.v_raw = random_raw(keep_nonzero);
      rd.pa_raw = random_raw(keep_nonzero);
      rd.pb_raw = random_raw(keep_nonzero);
      reading_queue.push_back(rd);
      if (rd.frame_ok) valid_left--;
    end
  endtask

  // Waits until every queued reading is taken and every status item has come,
  // then lets the back end run dry so that a dropped reading is finished too.
  task automatic settle();
    while (reading_queue.size() != 0 || push) @(posedge clk_i);
    while (status_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [LimW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Writes all seven registers back to back, then releases the channel.
  task automatic load_settings(int vg, int cag, int cbg, int pag, int pbg,
                               int vlim, int clim);
    write_reg(CfgVoltGain, LimW'(vg));
    write_reg(CfgCurrAGain, LimW'(cag));
    write_reg(CfgCurrBGain, LimW'(cbg));
    write_reg(CfgPowAGain, LimW'(pag));
    write_reg(CfgPowBGain, LimW'(pbg));
    write_reg(CfgVoltLimit, LimW'(vlim));
    write_reg(CfgCurrLimit, LimW'(clim));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed readings under the reset defaults: all-zero and all-ones
    // words, the power sign boundary, every chip including the two whose
    // ports lie outside the bank, and an invalid reading that must vanish.
    reading_queue.push_back(make_reading(1, 0, 0, 0, 0, 0, 0));
    reading_queue.push_back(make_reading(1, 0, '1, '1, '1, '1, '1));
    reading_queue.push_back(make_reading(1, 1, 1, 2, 3, 24'h7fffff, 24'h800000));
    reading_queue.push_back(make_reading(1, 2, 24'h800000, 24'h7fffff, 24'h123456,
                                         24'h800001, 24'h000001));
    reading_queue.push_back(make_reading(1, 3, 24'h0a5a5a, 24'h5a5a5a, 24'hffffff,
                                         24'hfffffe, 24'h400000));
    reading_queue.push_back(make_reading(1, 4, 274860, 274861, 4281750, 24'hc00000, 100));
    reading_queue.push_back(make_reading(1, 6, '1, '1, '1, '1, '1));
    reading_queue.push_back(make_reading(1, 7, '1, '1, '1, '1, '1));
    reading_queue.push_back(make_reading(0, 0, 5, 5, 5, 5, 5));
    // Keep chip 5 over both limits long enough for its flags to rise, then
    // drop it below them to clear the flags and runs at once.
    for (int n = 0; n < 12; n++)
      reading_queue.push_back(make_reading(1, 5, '1, 24'hf00000, '1, 24'h7fffff, '1));
    reading_queue.push_back(make_reading(1, 5, 0, 10, 0, 0, 0));
    settle();

    // First random phase: zero gains (divide by one), gains at both ends of
    // their range, an unreachable voltage limit and a zero current limit.
    // The receiver holds off for a long stretch right away so the block
    // fills up and has to stall its input.
    load_settings(0, 1, 65535, 65535, 0, 1677721500, 0);
    queue_random(35, 1'b0);
    @(posedge clk_i);
    rx_hold_req = 1'b1;
    settle();

    // Second phase: the idling swaps sides and the registers take random
    // values with limits near typical readings so the flags come and go.
    tx_idle_pct = 78;
    rx_idle_pct = 17;
    load_settings($urandom_range(1, 65535), $urandom_range(1, 65535),
                  $urandom_range(1, 65535), $urandom_range(1, 65535),
                  $urandom_range(1, 65535), $urandom_range(3000),
                  $urandom_range(20000));
    queue_random(35, 1'b0);
    settle();

    // Last phase at full speed: zero limits with small gains and nonzero
    // words keep every written port over its limits, long enough for the run
    // counters to wrap past 255 with the flags held.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_settings(1, 1, 2, 65535, 1, 0, 0);
    queue_random(300, 1'b1);
    settle();

    if (mismatches == 0 && status_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/mpso_pkg.sv
src/mpso_ram.sv
src/mpso_fifo.sv
src/mpso_div.sv
src/mpso_front.sv
src/mpso_back.sv
src/meter_port_scaling_overlimit_unit.sv
test/tb_top.sv
